FILE: src/tea_block_cipher_defines.svh
// Assertion macros for the cipher top level.
`ifndef TEA_BLOCK_CIPHER_DEFINES_SVH
`define TEA_BLOCK_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEVER(label, cond)
`endif

`endif

FILE: src/tea_pkg.sv
// Types, constants and the round mix function of the TEA cipher.
package tea_pkg;

  localparam int ROUNDS    = 32;
  localparam int LATENCY   = 2 * ROUNDS;
  localparam int CFG_IDX_W = 8;

  localparam logic [31:0] DELTA        = 32'h9E37_79B9;
  localparam logic [63:0] SUM_DEC_FULL = 64'(ROUNDS) * 64'(DELTA);
  localparam logic [31:0] SUM_DEC_INIT = SUM_DEC_FULL[31:0];
  localparam logic [63:0] SUM_ENC_FULL = 64'(ROUNDS + 1) * 64'(DELTA);
  localparam logic [31:0] SUM_ENC_END  = SUM_ENC_FULL[31:0];

  localparam logic [CFG_IDX_W-1:0] KEY_WORD0_IDX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] KEY_WORD1_IDX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] KEY_WORD2_IDX = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] KEY_WORD3_IDX = CFG_IDX_W'(3);

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] block_first;
    logic [31:0] block_second;
  } tea_in_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } tea_out_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_key_t;

  // One slot of the round chain: a block in flight with its running sum.
  typedef struct packed {
    logic        valid;
    logic        mode;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
  } tea_lane_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] t_shl;
    logic [31:0] t_sum;
    logic [31:0] t_shr;
    t_shl = (x << 4) + ka;
    t_sum = x + sum;
    t_shr = (x >> 5) + kb;
    return t_shl ^ t_sum ^ t_shr;
  endfunction

endpackage

FILE: src/tea_round_cell.sv
// One TEA round as a two-stage cell: one half-round per stage.
module tea_round_cell
  import tea_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tea_key_t  key,
  input  tea_lane_t lane_i,
  output tea_lane_t lane_o
);

  tea_lane_t mid_r, mid_nxt;
  tea_lane_t out_r, out_nxt;

  // First half: encrypt updates y, decrypt peels z.
  always_comb begin
    mid_nxt = lane_i;
    if (lane_i.mode == MODE_ENCRYPT) begin
      mid_nxt.y = lane_i.y + tea_mix(lane_i.z, lane_i.sum, key.k0, key.k1);
    end else begin
      mid_nxt.z = lane_i.z - tea_mix(lane_i.y, lane_i.sum, key.k2, key.k3);
    end
  end

  // Second half: finish the round and advance the sum for the next cell.
  always_comb begin
    out_nxt = mid_r;
    if (mid_r.mode == MODE_ENCRYPT) begin
      out_nxt.z   = mid_r.z + tea_mix(mid_r.y, mid_r.sum, key.k2, key.k3);
      out_nxt.sum = mid_r.sum + DELTA;
    end else begin
      out_nxt.y   = mid_r.y - tea_mix(mid_r.z, mid_r.sum, key.k0, key.k1);
      out_nxt.sum = mid_r.sum - DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= '0;
      out_r <= '0;
    end else begin
      mid_r <= mid_nxt;
      out_r <= out_nxt;
    end
  end

  assign lane_o = out_r;

endmodule

FILE: src/tea_block_cipher.sv
// Top level of the pipelined TEA block cipher: key registers and the round chain.
//
// Usage:
//   Write the 128-bit key through cfg_we / cfg_index / cfg_wdata, one 32-bit
//   word per write (index 0 to 3); writes to other indexes are dropped. Change
//   the key only while no block is in flight.
//   Present a block on in_data (mode, block_first, block_second) with start
//   high; it is taken at that clock edge. busy stays low, so a new block can
//   enter every cycle.
//   Each block passes a chain of 32 round cells, two register stages per cell
//   (one half-round each), so out_valid pulses with out_data once the block
//   has passed both stages of every cell. Throughput is one block per cycle.
//   out_valid is a one-cycle strobe; the receiver cannot stall, so every
//   result must be taken in the cycle it appears.
//   Reset (synchronous, rst_n low) clears the key to zero and drops every
//   block in flight.
module tea_block_cipher
  import tea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tea_in_t              in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  output tea_out_t             out_data
);

  `include "tea_block_cipher_defines.svh"

  tea_key_t  key_r;
  tea_lane_t lane [0:ROUNDS];
  tea_lane_t lane_in;
  logic      in_accept;
  logic      sum_end_ok;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        KEY_WORD0_IDX: key_r.k0 <= cfg_wdata;
        KEY_WORD1_IDX: key_r.k1 <= cfg_wdata;
        KEY_WORD2_IDX: key_r.k2 <= cfg_wdata;
        KEY_WORD3_IDX: key_r.k3 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Encrypt enters with the sum already advanced by one delta.
  always_comb begin
    lane_in.valid = in_accept;
    lane_in.mode  = in_data.mode;
    lane_in.y     = in_data.block_first;
    lane_in.z     = in_data.block_second;
    lane_in.sum   = (in_data.mode == MODE_ENCRYPT) ? DELTA : SUM_DEC_INIT;
  end

  assign lane[0] = lane_in;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    tea_round_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key    (key_r),
      .lane_i (lane[g]),
      .lane_o (lane[g+1])
    );
  end

  assign out_valid              = lane[ROUNDS].valid;
  assign out_data.result_first  = lane[ROUNDS].y;
  assign out_data.result_second = lane[ROUNDS].z;

  assign sum_end_ok = (lane[ROUNDS].mode == MODE_ENCRYPT) ? (lane[ROUNDS].sum == SUM_ENC_END)
                                                          : (lane[ROUNDS].sum == 32'h0);

  `ASSERT_NEVER(a_out_without_input, out_valid && !$past(in_accept, LATENCY))
  `ASSERT_IMPLIES(a_sum_at_end, out_valid, sum_end_ok)

endmodule

FILE: tb/tea_block_cipher_tb.sv
// Self-checking testbench for the pipelined TEA block cipher.
module tea_block_cipher_tb
  import tea_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BLOCKS = 64;
  // Indexes past the last key word; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_PAST = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_TOP = {CFG_IDX_W{1'b1}};

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tea_in_t in_data = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic out_valid;
  tea_out_t out_data;

  logic [31:0] key_words [4] = '{default: 32'h0};
  tea_in_t pending_blocks [$];
  tea_out_t expected_blocks [$];
  int blocks_issued = 0;
  int blocks_accepted = 0;
  int sender_idle_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  tea_block_cipher u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] half_round(input logic [31:0] x, input logic [31:0] s,
                                             input logic [31:0] ka, input logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  // Run all rounds on one block under the current key.
  function automatic tea_out_t tea_cipher_block(input tea_in_t blk);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] run_sum;
    tea_out_t res;
    y = blk.block_first;
    z = blk.block_second;
    if (blk.mode == MODE_DECRYPT) begin
      run_sum = 32'(ROUNDS) * DELTA;
      for (int r = 0; r < ROUNDS; r++) begin
        z -= half_round(y, run_sum, key_words[2], key_words[3]);
        y -= half_round(z, run_sum, key_words[0], key_words[1]);
        run_sum -= DELTA;
      end
    end else begin
      run_sum = 32'h0;
      for (int r = 0; r < ROUNDS; r++) begin
        run_sum += DELTA;
        y += half_round(z, run_sum, key_words[0], key_words[1]);
        z += half_round(y, run_sum, key_words[2], key_words[3]);
      end
    end
    res.result_first = y;
    res.result_second = z;
    return res;
  endfunction

  // Driver: present queued blocks, idle at random, scramble the bus while idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        expected_blocks.push_back(tea_cipher_block(in_data));
        blocks_accepted++;
      end
      if (!(start && busy)) begin
        if (pending_blocks.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          in_data <= pending_blocks.pop_front();
        end else begin
          start <= 1'b0;
          in_data <= {1'($urandom_range(1)), 32'($urandom), 32'($urandom)};
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest pending block.
  always @(posedge clk) begin
    tea_out_t want;
    if (rst_n && out_valid) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result: first=%h second=%h",
               out_data.result_first, out_data.result_second);
        err_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (out_data.result_first !== want.result_first) begin
          $error("result_first: expected %h, got %h", want.result_first,
                 out_data.result_first);
          err_count++;
        end
        if (out_data.result_second !== want.result_second) begin
          $error("result_second: expected %h, got %h", want.result_second,
                 out_data.result_second);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tea_block_cipher_tb: errors");
      $finish;
    end
  end

  task automatic queue_block(input logic mode, input logic [31:0] a, input logic [31:0] b);
    tea_in_t blk;
    blk.mode = mode;
    blk.block_first = a;
    blk.block_second = b;
    pending_blocks.push_back(blk);
    blocks_issued++;
  endtask

  // Hold until every block is accepted and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (blocks_accepted != blocks_issued || expected_blocks.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= KEY_WORD3_IDX)
      key_words[idx[1:0]] = val;
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    write_cfg(KEY_WORD0_IDX, k0);
    write_cfg(KEY_WORD1_IDX, k1);
    write_cfg(KEY_WORD2_IDX, k2);
    write_cfg(KEY_WORD3_IDX, k3);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly random blocks; some are encrypt/decrypt round trips of one plaintext.
  task automatic run_random(input int count);
    logic [31:0] a;
    logic [31:0] b;
    tea_in_t plain;
    tea_out_t cipher;
    for (int i = 0; i < count; i++) begin
      a = pick_word();
      b = pick_word();
      if ($urandom_range(3) == 0) begin
        plain.mode = MODE_ENCRYPT;
        plain.block_first = a;
        plain.block_second = b;
        cipher = tea_cipher_block(plain);
        queue_block(MODE_ENCRYPT, a, b);
        queue_block(MODE_DECRYPT, cipher.result_first, cipher.result_second);
      end else begin
        queue_block(1'($urandom_range(1)), a, b);
      end
    end
  endtask

  initial begin
    int idle_plan [3];
    idle_plan = '{18, 51, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset key, never written: all-zero key.
    for (int m = 0; m < 2; m++) begin
      queue_block(m[0], 32'h0, 32'h0);
      queue_block(m[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_block(m[0], 32'h0, 32'hFFFF_FFFF);
      queue_block(m[0], 32'hFFFF_FFFF, 32'h0);
      queue_block(m[0], 32'hAAAA_AAAA, 32'h5555_5555);
      queue_block(m[0], 32'h8000_0000, 32'h0000_0001);
    end
    wait_drained();

    // Out-of-range indexes must leave the key alone.
    write_cfg(KEY_IDX_PAST, $urandom);
    write_cfg(KEY_IDX_TOP, $urandom);
    queue_block(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    wait_drained();

    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(MODE_ENCRYPT, 32'h0, 32'h0);
    queue_block(MODE_DECRYPT, 32'h0, 32'h0);
    queue_block(MODE_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(MODE_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(MODE_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_block(MODE_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_plan[ph];
      for (int s = 0; s < 2; s++) begin
        if (ph == 2 && s == 1)
          load_key(32'h0, 32'h0, 32'h0, 32'h0);
        else
          load_key($urandom, $urandom, $urandom, $urandom);
        run_random(RANDOM_BLOCKS);
        wait_drained();
      end
    end

    repeat (LATENCY + 16) @(posedge clk);
    if (expected_blocks.size() != 0) begin
      $error("%0d results never arrived", expected_blocks.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tea_block_cipher_tb: clean");
    end else begin
      $display("tea_block_cipher_tb: errors");
    end
    $finish;
  end

endmodule

FILE: tea_block_cipher.f
+incdir+src
src/tea_pkg.sv
src/tea_round_cell.sv
src/tea_block_cipher.sv
tb/tea_block_cipher_tb.sv
